### sv/csma_pkg.sv
package csma_pkg;

  // largest backoff exponent the engine will ever use
  localparam int unsigned EXPONENT_LIMIT = 8;

  localparam int unsigned OPCODE_W     = 2;
  localparam int unsigned LEVEL_W      = 8;
  localparam int unsigned RANDOM_W     = 8;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned PERIOD_W     = 8;
  localparam int unsigned BUSY_W       = 4;
  localparam int unsigned EXP_W        = 4;
  localparam int unsigned BACKOFFS_W   = 3;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_START = 2'd0,
    OP_TICK  = 2'd1,
    OP_RSSI  = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_BACKOFF = 3'd0,
    ST_CHECK   = 3'd1,
    ST_GRANT   = 3'd2,
    ST_FAIL    = 3'd3,
    ST_IGNORED = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_EXP      = 2'd0,
    CFG_MAX_EXP      = 2'd1,
    CFG_MAX_BACKOFFS = 2'd2,
    CFG_IDLE_THRESH  = 2'd3
  } cfg_idx_e;

  // clamp a configured exponent to the supported limit
  function automatic logic [EXP_W-1:0] clamp_exp(input logic [EXP_W-1:0] e);
    logic [EXP_W-1:0] r;
    r = e;
    if (int'(e) > EXPONENT_LIMIT) r = EXP_W'(EXPONENT_LIMIT);
    return r;
  endfunction

endpackage

### sv/csma_ca_backoff_engine.sv
// Unslotted CSMA-CA channel-access engine. Each input transaction is one event:
// start (begin an access attempt), tick (one backoff period elapsed) or an RSSI
// sample answering a channel-check request. Every event produces exactly one
// result transaction carrying the status, the periods still to wait, the busy
// count and the exponent in use. One event is taken per clock cycle while the
// result consumer keeps up; a stall holds the input register. An event crosses
// the input register, then the state update into the result register. The
// loop through the phase/tries/exponent/delay registers sets the rate. A start
// always restarts the attempt; ticks and samples that do not fit the current
// phase report the current state with status "ignored". Configuration is a
// plain write port (index 0 min exponent, 1 max exponent, 2 max backoffs,
// 3 idle threshold) and is to be written only while no event is in flight.
module csma_ca_backoff_engine (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // event channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [csma_pkg::OPCODE_W-1:0]      opcode_i,
  input  logic [csma_pkg::LEVEL_W-1:0]       rssi_i,
  input  logic [csma_pkg::RANDOM_W-1:0]      random_bits_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [csma_pkg::STATUS_W-1:0]      status_o,
  output logic [csma_pkg::PERIOD_W-1:0]      periods_remaining_o,
  output logic [csma_pkg::BUSY_W-1:0]        busy_count_o,
  output logic [csma_pkg::EXP_W-1:0]         exponent_now_o,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [csma_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [csma_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import csma_pkg::*;

  // phase of the current access attempt
  localparam logic [1:0] PHASE_IDLE    = 2'd0;
  localparam logic [1:0] PHASE_BACKOFF = 2'd1;
  localparam logic [1:0] PHASE_CHECK   = 2'd2;

  // configuration registers
  logic [EXP_W-1:0]      min_exp_q;
  logic [EXP_W-1:0]      max_exp_q;
  logic [BACKOFFS_W-1:0] max_backoffs_q;
  logic [LEVEL_W-1:0]    idle_thresh_q;

  // engine state
  logic [1:0]            phase_q, phase_d;
  logic [BUSY_W-1:0]     tries_q, tries_d;
  logic [EXP_W-1:0]      exp_q, exp_d;
  logic [PERIOD_W-1:0]   periods_q, periods_d;

  // input register stage
  logic                  s1_valid_q;
  opcode_e               s1_opcode_q;
  logic [LEVEL_W-1:0]    s1_rssi_q;
  logic [RANDOM_W-1:0]   s1_random_q;
  logic                  s1_fire;

  // result register
  logic                  out_valid_q;
  status_e               status_q, status_d;
  logic [PERIOD_W-1:0]   out_periods_q;
  logic [BUSY_W-1:0]     out_busy_q;
  logic [EXP_W-1:0]      out_exp_q;

  // datapath temporaries
  logic                  draw;
  logic [BUSY_W-1:0]     tries_inc;
  logic [EXP_W:0]        exp_up;
  logic [EXP_W-1:0]      exp_cap;
  logic [PERIOD_W:0]     mask_wide;
  logic [PERIOD_W-1:0]   delay;
  logic [PERIOD_W-1:0]   periods_dec;

  // the event stage moves on whenever the result register is free or draining
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_exp_q      <= EXP_W'(3);
      max_exp_q      <= EXP_W'(5);
      max_backoffs_q <= BACKOFFS_W'(4);
      idle_thresh_q  <= LEVEL_W'(128);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_EXP:      min_exp_q      <= cfg_data_i[EXP_W-1:0];
        CFG_MAX_EXP:      max_exp_q      <= cfg_data_i[EXP_W-1:0];
        CFG_MAX_BACKOFFS: max_backoffs_q <= cfg_data_i[BACKOFFS_W-1:0];
        CFG_IDLE_THRESH:  idle_thresh_q  <= cfg_data_i[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // capture an accepted event transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_opcode_q <= opcode_e'(opcode_i);
      s1_rssi_q   <= rssi_i;
      s1_random_q <= random_bits_i;
    end
  end

  // per-event state update
  always_comb begin
    phase_d   = phase_q;
    tries_d   = tries_q;
    exp_d     = exp_q;
    periods_d = periods_q;
    status_d  = ST_IGNORED;
    draw      = 1'b0;

    tries_inc   = tries_q + 1'b1;
    exp_up      = {1'b0, exp_q} + 1'b1;
    exp_cap     = clamp_exp(max_exp_q);
    periods_dec = periods_q - 1'b1;

    unique case (s1_opcode_q)
      OP_START: begin
        tries_d = '0;
        exp_d   = clamp_exp(min_exp_q);
        draw    = 1'b1;
      end
      OP_TICK: begin
        if (phase_q == PHASE_BACKOFF) begin
          periods_d = periods_dec;
          if (periods_dec == '0) begin
            phase_d  = PHASE_CHECK;
            status_d = ST_CHECK;
          end else begin
            status_d = ST_BACKOFF;
          end
        end
      end
      OP_RSSI: begin
        if (phase_q == PHASE_CHECK) begin
          if (s1_rssi_q < idle_thresh_q) begin
            phase_d   = PHASE_IDLE;
            periods_d = '0;
            status_d  = ST_GRANT;
          end else begin
            tries_d = tries_inc;
            // a cap below the current exponent lowers it
            exp_d   = (exp_up < {1'b0, exp_cap}) ? exp_up[EXP_W-1:0] : exp_cap;
            if (tries_inc > {1'b0, max_backoffs_q}) begin
              phase_d   = PHASE_IDLE;
              periods_d = '0;
              status_d  = ST_FAIL;
            end else begin
              draw = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase

    // mask of exp_d low bits; any exponent past the width gives all ones
    mask_wide = ({{PERIOD_W{1'b0}}, 1'b1} << exp_d) - 1'b1;
    delay     = s1_random_q & mask_wide[PERIOD_W-1:0];

    if (draw) begin
      periods_d = delay;
      if (delay == '0) begin
        // zero delay drawn: check the channel right away
        phase_d  = PHASE_CHECK;
        status_d = ST_CHECK;
      end else begin
        phase_d  = PHASE_BACKOFF;
        status_d = ST_BACKOFF;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PHASE_IDLE;
      tries_q   <= '0;
      exp_q     <= '0;
      periods_q <= '0;
    end else if (s1_fire) begin
      phase_q   <= phase_d;
      tries_q   <= tries_d;
      exp_q     <= exp_d;
      periods_q <= periods_d;
    end
  end

  // result register, holds while the consumer stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      status_q      <= status_d;
      out_periods_q <= periods_d;
      out_busy_q    <= tries_d;
      out_exp_q     <= exp_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign periods_remaining_o = out_periods_q;
  assign busy_count_o        = out_busy_q;
  assign exponent_now_o      = out_exp_q;

endmodule

### sv/csma_chk.sv
module csma_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [csma_pkg::STATUS_W-1:0]  status_o,
  input logic [csma_pkg::PERIOD_W-1:0]  periods_remaining_o,
  input logic [csma_pkg::BUSY_W-1:0]    busy_count_o,
  input logic [csma_pkg::EXP_W-1:0]     exponent_now_o
);
  import csma_pkg::*;

  // grant or failure always ends the attempt with no delay left
  a_end_clears_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_GRANT || status_o == ST_FAIL)
      |-> periods_remaining_o == '0)
    else $error("delay left after grant or failure");

  // backing off means a nonzero delay, a check request means none
  a_delay_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_BACKOFF || status_o == ST_CHECK)
      |-> ((status_o == ST_BACKOFF) == (periods_remaining_o != '0)))
    else $error("delay does not match backoff or check status");

  // exponent never exceeds the supported limit
  a_exp_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(exponent_now_o) <= EXPONENT_LIMIT)
    else $error("exponent beyond limit");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i
      |=> out_valid_o && $stable(status_o) && $stable(periods_remaining_o)
          && $stable(busy_count_o) && $stable(exponent_now_o))
    else $error("result changed while stalled");

endmodule

bind csma_ca_backoff_engine csma_chk u_csma_chk (.*);

### sim/csma_ca_backoff_engine_test.sv
`timescale 1ns / 100ps

module csma_ca_backoff_engine_test;
  import csma_pkg::*;

  // timing of the run
  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 10;
  // a result crosses the engine's input register, then its result register
  localparam int RESULT_LATENCY = 2;
  localparam int SETTLE_CYCLES  = RESULT_LATENCY + 2;
  localparam int TIMEOUT_CYCLES = 400_000;
  localparam int MAX_GAP        = 19;

  // stimulus volume
  localparam int RANDOM_TARGET  = 1275;
  localparam int PHASE_EVENTS   = 160;
  localparam int SESSION_CAP    = 80;
  localparam int HOLD_CYCLES    = 300;
  localparam int STALL_EVENTS   = 40;
  localparam int MAX_PRINTED    = 50;

  // opcode that the engine has no meaning for
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  // phases of one access attempt in the engine
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BACKOFF,
    PH_CHECK
  } access_phase_e;

  typedef struct packed {
    status_e              status;
    logic [PERIOD_W-1:0]  periods;
    logic [BUSY_W-1:0]    busy;
    logic [EXP_W-1:0]     exponent;
  } access_result_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // event channel
  logic                  ev_valid  = 1'b0;
  logic                  ev_ready;
  logic [OPCODE_W-1:0]   ev_opcode = '0;
  logic [LEVEL_W-1:0]    ev_rssi   = '0;
  logic [RANDOM_W-1:0]   ev_random = '0;

  // result channel
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  logic [STATUS_W-1:0]   res_status;
  logic [PERIOD_W-1:0]   res_periods;
  logic [BUSY_W-1:0]     res_busy;
  logic [EXP_W-1:0]      res_exponent;

  // register write port
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // pacing of both sides, and the long receiver hold-off
  bit send_pace = 1'b1;
  bit recv_pace = 1'b1;
  bit rx_hold   = 1'b0;
  int rx_wait   = 0;

  // predicted engine registers and state
  logic [EXP_W-1:0]      cfg_min_exp;
  logic [EXP_W-1:0]      cfg_max_exp;
  logic [BACKOFFS_W-1:0] cfg_max_backoffs;
  logic [LEVEL_W-1:0]    cfg_idle_thr;
  access_phase_e         eng_phase;
  logic [BUSY_W-1:0]     eng_tries;
  logic [EXP_W-1:0]      eng_exp;
  logic [PERIOD_W-1:0]   eng_periods;

  // results still to come, oldest first
  access_result_t awaited_results[$];

  int events_sent     = 0;
  int results_checked = 0;
  int settings_used   = 0;
  int grants_seen     = 0;
  int failures_seen   = 0;
  int ignored_seen    = 0;
  int mismatch_count  = 0;

  csma_ca_backoff_engine u_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (ev_valid),
    .in_ready_o          (ev_ready),
    .opcode_i            (ev_opcode),
    .rssi_i              (ev_rssi),
    .random_bits_i       (ev_random),
    .out_valid_o         (res_valid),
    .out_ready_i         (res_ready),
    .status_o            (res_status),
    .periods_remaining_o (res_periods),
    .busy_count_o        (res_busy),
    .exponent_now_o      (res_exponent),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // access engine prediction
  // ---------------------------------------------------------------------------

  // register values after reset
  function automatic void reset_engine_model();
    cfg_min_exp      = 4'd3;
    cfg_max_exp      = 4'd5;
    cfg_max_backoffs = 3'd4;
    cfg_idle_thr     = 8'd128;
    eng_phase        = PH_IDLE;
    eng_tries        = '0;
    eng_exp          = '0;
    eng_periods      = '0;
  endfunction

  // exponents above the supported limit are pulled down to it
  function automatic logic [EXP_W-1:0] limit_exp(input logic [EXP_W-1:0] e);
    if (int'(e) > EXPONENT_LIMIT) begin
      return EXP_W'(EXPONENT_LIMIT);
    end
    return e;
  endfunction

  // new delay from the random bits under the exponent mask
  function automatic status_e draw_backoff(input logic [RANDOM_W-1:0] rnd);
    logic [PERIOD_W-1:0] mask;
    if (int'(eng_exp) >= PERIOD_W) begin
      mask = '1;
    end else begin
      mask = PERIOD_W'((9'd1 << eng_exp) - 9'd1);
    end
    eng_periods = rnd & mask;
    // zero delay goes straight to the channel check
    if (eng_periods == '0) begin
      eng_phase = PH_CHECK;
      return ST_CHECK;
    end
    eng_phase = PH_BACKOFF;
    return ST_BACKOFF;
  endfunction

  // one event through the engine, returns the result it must produce
  function automatic access_result_t engine_next(input logic [OPCODE_W-1:0] op,
                                                 input logic [LEVEL_W-1:0] rssi,
                                                 input logic [RANDOM_W-1:0] rnd);
    access_result_t r;
    status_e        st;
    logic [EXP_W-1:0] cap;
    logic [EXP_W:0]   up;
    st = ST_IGNORED;
    case (op)
      OP_START: begin
        // a start always restarts the attempt
        eng_tries = '0;
        eng_exp   = limit_exp(cfg_min_exp);
        st        = draw_backoff(rnd);
      end
      OP_TICK: begin
        if (eng_phase == PH_BACKOFF) begin
          eng_periods = eng_periods - 1'b1;
          if (eng_periods == '0) begin
            eng_phase = PH_CHECK;
            st        = ST_CHECK;
          end else begin
            st = ST_BACKOFF;
          end
        end
      end
      OP_RSSI: begin
        if (eng_phase == PH_CHECK) begin
          if (rssi < cfg_idle_thr) begin
            eng_phase   = PH_IDLE;
            eng_periods = '0;
            st          = ST_GRANT;
          end else begin
            // busy channel: count it and widen the window up to the cap,
            // a cap under the current exponent lowers it
            cap       = limit_exp(cfg_max_exp);
            up        = {1'b0, eng_exp} + 1'b1;
            eng_tries = eng_tries + 1'b1;
            eng_exp   = (up < {1'b0, cap}) ? up[EXP_W-1:0] : cap;
            if (eng_tries > {1'b0, cfg_max_backoffs}) begin
              eng_phase   = PH_IDLE;
              eng_periods = '0;
              st          = ST_FAIL;
            end else begin
              st = draw_backoff(rnd);
            end
          end
        end
      end
      default: ;
    endcase
    r.status   = st;
    r.periods  = eng_periods;
    r.busy     = eng_tries;
    r.exponent = eng_exp;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls, long hold-off, field checks
  // ---------------------------------------------------------------------------

  always @(posedge clk or negedge rst_n) begin : result_sink
    int stall;
    if (!rst_n) begin
      res_ready <= 1'b0;
      rx_wait   <= 0;
    end else if (rx_hold) begin
      res_ready <= 1'b0;
    end else if (rx_wait != 0) begin
      rx_wait   <= rx_wait - 1;
      res_ready <= 1'b0;
    end else if (res_ready && res_valid) begin
      // transaction taken, draw the wait before the next one
      stall = recv_pace ? $urandom_range(0, MAX_GAP) : 0;
      if (stall == 0) begin
        res_ready <= 1'b1;
      end else begin
        res_ready <= 1'b0;
        rx_wait   <= stall - 1;
      end
    end else begin
      res_ready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatch_count < MAX_PRINTED) begin
      $display("mismatch at %0t, result %0d: %s got %0d, expected %0d",
               $realtime, results_checked, what, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin : result_check
    access_result_t want;
    if (rst_n && res_valid && res_ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing awaited, status", 8'(res_status), 8'd0);
      end else begin
        want = awaited_results.pop_front();
        if (res_status !== want.status) begin
          report_mismatch("status", 8'(res_status), 8'(want.status));
        end
        if (res_periods !== want.periods) begin
          report_mismatch("periods_remaining", res_periods, want.periods);
        end
        if (res_busy !== want.busy) begin
          report_mismatch("busy_count", 8'(res_busy), 8'(want.busy));
        end
        if (res_exponent !== want.exponent) begin
          report_mismatch("exponent_now", 8'(res_exponent), 8'(want.exponent));
        end
      end
      results_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // event side
  // ---------------------------------------------------------------------------

  // offer one event, hold it until taken, then predict its result
  task automatic send_event(input logic [OPCODE_W-1:0] op,
                            input logic [LEVEL_W-1:0] rssi,
                            input logic [RANDOM_W-1:0] rnd);
    access_result_t r;
    int gap;
    gap = send_pace ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      ev_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ev_valid  <= 1'b1;
    ev_opcode <= op;
    ev_rssi   <= rssi;
    ev_random <= rnd;
    @(posedge clk);
    while (!ev_ready) @(posedge clk);
    r = engine_next(op, rssi, rnd);
    awaited_results.push_back(r);
    events_sent++;
    case (r.status)
      ST_GRANT:   grants_seen++;
      ST_FAIL:    failures_seen++;
      ST_IGNORED: ignored_seen++;
      default: ;
    endcase
  endtask

  // stop offering and wait until every result is back and the pipe is empty
  task automatic drain_results();
    ev_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      CFG_MIN_EXP:      cfg_min_exp      = value[EXP_W-1:0];
      CFG_MAX_EXP:      cfg_max_exp      = value[EXP_W-1:0];
      CFG_MAX_BACKOFFS: cfg_max_backoffs = value[BACKOFFS_W-1:0];
      CFG_IDLE_THRESH:  cfg_idle_thr     = value[LEVEL_W-1:0];
      default: ;
    endcase
  endtask

  // registers only change with nothing in flight
  task automatic program_regs(input logic [EXP_W-1:0] min_e, input logic [EXP_W-1:0] max_e,
                              input logic [BACKOFFS_W-1:0] backoffs,
                              input logic [LEVEL_W-1:0] thr);
    drain_results();
    cfg_write(CFG_MIN_EXP, CFG_DATA_W'(min_e));
    cfg_write(CFG_MAX_EXP, CFG_DATA_W'(max_e));
    cfg_write(CFG_MAX_BACKOFFS, CFG_DATA_W'(backoffs));
    cfg_write(CFG_IDLE_THRESH, thr);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic set_pacing(input bit on);
    send_pace = on;
    recv_pace <= on;
  endtask

  // next event of a well-formed attempt, with some noise mixed in
  task automatic send_session_step();
    logic [LEVEL_W-1:0] level;
    if ($urandom_range(0, 9) == 0) begin
      send_event(OPCODE_W'($urandom_range(0, 3)), LEVEL_W'($urandom), RANDOM_W'($urandom));
    end else if (eng_phase == PH_BACKOFF) begin
      send_event(OP_TICK, LEVEL_W'($urandom), RANDOM_W'($urandom));
    end else if (eng_phase == PH_CHECK) begin
      // busy more often than idle so that attempts also run out
      if (cfg_idle_thr != '0 && $urandom_range(0, 2) == 0) begin
        level = LEVEL_W'($urandom_range(0, int'(cfg_idle_thr) - 1));
      end else begin
        level = LEVEL_W'($urandom_range(int'(cfg_idle_thr), 255));
      end
      send_event(OP_RSSI, level, RANDOM_W'($urandom));
    end else begin
      send_event(OP_START, LEVEL_W'($urandom), RANDOM_W'($urandom));
    end
  endtask

  // one access attempt from start to grant or failure, bounded in length
  task automatic run_session();
    int steps;
    send_event(OP_START, LEVEL_W'($urandom), RANDOM_W'($urandom));
    steps = 1;
    while (eng_phase != PH_IDLE && steps < SESSION_CAP) begin
      send_session_step();
      steps++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // events that do not fit the phase, restart, zero delay, threshold edges
  task automatic test_default_registers();
    set_pacing(1'b1);
    send_event(OP_UNUSED, 8'h00, 8'h00);   // unused opcode while idle
    send_event(OP_TICK,   8'h00, 8'hFF);   // tick while idle
    send_event(OP_RSSI,   8'h00, 8'hFF);   // sample with no check pending
    send_event(OP_START,  8'hFF, 8'h00);   // zero delay, check at once
    send_event(OP_TICK,   8'h00, 8'h00);   // tick while waiting for a sample
    send_event(OP_RSSI,   8'd128, 8'h03);  // level equal to threshold is busy
    send_event(OP_RSSI,   8'h00, 8'h00);   // sample during backoff
    send_event(OP_TICK,   8'h00, 8'h00);
    send_event(OP_START,  8'h00, 8'hFF);   // restart while backing off
    send_event(OP_UNUSED, 8'hFF, 8'hFF);   // unused opcode while backing off
    send_event(OP_START,  8'h00, 8'h08);   // bits above the mask dropped
    send_event(OP_RSSI,   8'd127, 8'h00);  // just under threshold grants
  endtask

  // exponents past the limit, cap under minimum, threshold extremes
  task automatic test_register_extremes();
    program_regs(4'd15, 4'd15, 3'd0, 8'd0);
    send_event(OP_START, 8'h00, 8'hA5);    // exponent clamped, full mask
    send_event(OP_TICK,  8'h00, 8'h00);
    send_event(OP_START, 8'h00, 8'h00);
    send_event(OP_RSSI,  8'h00, 8'h00);    // nothing is idle, first busy fails
    send_event(OP_RSSI,  8'h00, 8'h00);    // after failure nothing pending
    program_regs(4'd8, 4'd2, 3'd7, 8'd255);
    send_event(OP_START, 8'h00, 8'h00);
    send_event(OP_RSSI,  8'd255, 8'h04);   // cap lowers the exponent
    send_event(OP_RSSI,  8'd254, 8'h00);
    program_regs(4'd0, 4'd8, 3'd7, 8'd200);
    send_event(OP_START, 8'h00, 8'hFF);    // exponent zero, empty mask
    send_event(OP_RSSI,  8'd255, 8'hFF);
    send_event(OP_TICK,  8'h00, 8'h00);    // counts down to the check
    send_event(OP_RSSI,  8'd199, 8'h00);
  endtask

  // many attempts under a string of settings, paced and unpaced
  task automatic test_random_sessions();
    int phase_no;
    int phase_start;
    logic [EXP_W-1:0] min_e;
    logic [EXP_W-1:0] max_e;
    phase_no = 0;
    while (events_sent < RANDOM_TARGET) begin
      case (phase_no % 6)
        0: program_regs(4'd0, 4'd0, 3'd0, 8'd0);
        1: program_regs(4'd15, 4'd15, 3'd7, 8'd255);
        default: begin
          // mostly short windows so that attempts end quickly
          if ($urandom_range(0, 3) == 0) begin
            min_e = EXP_W'($urandom_range(0, 15));
            max_e = EXP_W'($urandom_range(0, 15));
          end else begin
            min_e = EXP_W'($urandom_range(0, 3));
            max_e = EXP_W'($urandom_range(0, 5));
          end
          program_regs(min_e, max_e, BACKOFFS_W'($urandom_range(0, 7)),
                       LEVEL_W'($urandom));
        end
      endcase
      set_pacing(phase_no % 3 != 2);
      phase_start = events_sent;
      while (events_sent - phase_start < PHASE_EVENTS) run_session();
      phase_no++;
    end
  endtask

  // receiver holds off while events keep coming, then sender waits it out
  task automatic test_full_pipeline_stall();
    program_regs(4'd2, 4'd4, 3'd3, 8'd100);
    set_pacing(1'b0);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    repeat (STALL_EVENTS) send_session_step();
    drain_results();
    set_pacing(1'b1);
    repeat (STALL_EVENTS) send_session_step();
  endtask

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------

  initial begin
    reset_engine_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_registers();
    test_register_extremes();
    test_random_sessions();
    test_full_pipeline_stall();

    drain_results();
    repeat (RESULT_LATENCY * 4) @(posedge clk);
    if (awaited_results.size() != 0) begin
      report_mismatch("results never delivered", 8'(awaited_results.size()), 8'd0);
    end

    $display("run covered %0d events under %0d register settings, %0d results checked",
             events_sent, settings_used, results_checked);
    $display("attempts granted %0d, attempts failed %0d, events ignored %0d",
             grants_seen, failures_seen, ignored_seen);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hard stop if the run hangs
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d results outstanding", awaited_results.size());
    $display("Verification failed");
    $finish;
  end

endmodule
